[sv/lwe_dec_pkg.sv]
// Shared types and constants for the LWE decrypt unit.
package lwe_dec_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned MSG_W     = 16;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_CIPHER_MODULUS = 1'b0;
   localparam csr_idx_type CSR_PLAIN_MODULUS  = 1'b1;

   localparam logic [DATA_W-1:0] CIPHER_MODULUS_RESET = 32'd65537;
   localparam logic [MSG_W-1:0]  PLAIN_MODULUS_RESET  = 16'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RED_A,
      ST_RED_S,
      ST_RED_ACC,
      ST_MUL,
      ST_SUM,
      ST_RED_B,
      ST_PHASE,
      ST_RED_PH,
      ST_RED_QP,
      ST_EMIT
   } lwe_state_type;

   // Control for one step of the shared modular unit.
   typedef struct packed {
      logic dbl;
      logic add;
   } lwe_op_type;

endpackage

[sv/lwe_dec_modunit.sv]
// Shared modular step: optional doubling mod m, then optional add mod m.
module lwe_dec_modunit #(
   parameter int unsigned UW = 32
) (
   input  lwe_dec_pkg::lwe_op_type op,
   input  logic [UW-1:0]           acc_val,
   input  logic [UW-1:0]           addend,
   input  logic [UW-1:0]           modulus,
   output logic [UW-1:0]           result
);
   import lwe_dec_pkg::*;

   logic [UW:0]   mod_ext;
   logic [UW:0]   dbl_sum;
   logic [UW-1:0] dbl_red;
   logic [UW:0]   add_sum;

   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl_sum = op.dbl ? {acc_val, 1'b0} : {1'b0, acc_val};
      dbl_red = (dbl_sum >= mod_ext) ? UW'(dbl_sum - mod_ext) : dbl_sum[UW-1:0];
      add_sum = {1'b0, dbl_red} + (op.add ? {1'b0, addend} : {(UW+1){1'b0}});
      result  = (add_sum >= mod_ext) ? UW'(add_sum - mod_ext) : add_sum[UW-1:0];
   end

endmodule

[sv/lwe_decrypt_unit.sv]
// Scalar LWE decryption: modular inner product, phase, centering and reduction mod p.
// A word with reduced operands goes through load, a bit-serial multiply (one step per bit
// through the shared modular unit) and the sum into the accumulator; each operand or
// accumulator not below q first takes a bit-serial reduction.
// A last word then adds the phase and a bit-serial reduction mod p, a second one
// when the phase lies in the upper half, then loads the output register,
// held for as long as the previous result word is still stalled.
// Synchronous reset: sequencer idle, accumulator zero, q = 65537, p = 4, no result held.
module lwe_decrypt_unit #(
   parameter int unsigned MOD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lwe_dec_pkg::DATA_W-1:0]      req_cipher_coeff,
   input  logic [lwe_dec_pkg::DATA_W-1:0]      req_key_coeff,
   input  logic [lwe_dec_pkg::DATA_W-1:0]      req_cipher_body,
   input  logic                                req_last_coeff,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lwe_dec_pkg::MSG_W-1:0]       rsp_message,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  lwe_dec_pkg::csr_idx_type            csr_index,
   input  logic [lwe_dec_pkg::DATA_W-1:0]      csr_wdata
);
   import lwe_dec_pkg::*;

   localparam int unsigned DW    = (MOD_WIDTH < DATA_W) ? MOD_WIDTH : DATA_W;
   localparam int unsigned UW    = (DW > MSG_W) ? DW : MSG_W;
   localparam int unsigned CNT_W = $clog2(DW);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DW - 1);

   lwe_state_type state_ff, state_in;

   logic [DW-1:0]    a_ff, a_in;
   logic [DW-1:0]    s_ff, s_in;
   logic [DW-1:0]    b_ff, b_in;
   logic [DW-1:0]    acc_ff, acc_in;
   logic             last_ff, last_in;
   logic [DW-1:0]    q_ff;
   logic [MSG_W-1:0] p_ff;
   logic [DW-1:0]    src_ff, src_in;
   logic [UW-1:0]    r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    phase_ff, phase_in;
   logic             hi_ff, hi_in;
   logic [MSG_W-1:0] pm_ff, pm_in;
   logic [MSG_W-1:0] msg_ff, msg_in;
   logic             rsp_valid_ff;
   logic [MSG_W-1:0] rsp_message_ff;

   lwe_op_type       unit_op;
   logic [UW-1:0]    unit_r;
   logic [UW-1:0]    unit_addend;
   logic [UW-1:0]    unit_mod;
   logic [UW-1:0]    unit_out;

   logic             start;
   logic             out_load;
   logic             iter_done;
   logic             q_lt2;
   logic             need_a, need_s, need_acc, need_b;
   logic [DW-1:0]    phase_calc;
   logic [MSG_W-1:0] qm;
   logic [MSG_W:0]   center_sum;

   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_message = rsp_message_ff;

   assign iter_done = (cnt_ff == '0);
   assign q_lt2     = (q_ff[DW-1:1] == '0);
   assign need_a    = (a_ff >= q_ff);
   assign need_s    = (s_ff >= q_ff);
   assign need_acc  = (acc_ff >= q_ff);
   assign need_b    = (b_ff >= q_ff);

   assign phase_calc = (b_ff >= acc_ff) ? (b_ff - acc_ff) : (q_ff - (acc_ff - b_ff));
   assign qm         = unit_out[MSG_W-1:0];
   assign center_sum = {1'b0, pm_ff} + {1'b0, p_ff} - {1'b0, qm};

   // Operand select for the shared unit
   always_comb begin
      unit_op.dbl = 1'b1;
      unit_op.add = src_ff[DW-1];
      unit_r      = r_ff;
      unit_addend = UW'(1);
      unit_mod    = UW'(q_ff);
      case (state_ff)
         ST_MUL: begin
            unit_addend = UW'(a_ff);
         end
         ST_SUM: begin
            unit_op.dbl = 1'b0;
            unit_op.add = 1'b1;
            unit_r      = UW'(acc_ff);
            unit_addend = r_ff;
         end
         ST_RED_PH, ST_RED_QP: begin
            unit_mod = UW'(p_ff);
         end
         default: begin
         end
      endcase
   end

   lwe_dec_modunit #(
      .UW(UW)
   ) u_modunit (
      .op      (unit_op),
      .acc_val (unit_r),
      .addend  (unit_addend),
      .modulus (unit_mod),
      .result  (unit_out)
   );

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      s_in     = s_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      last_in  = last_ff;
      src_in   = src_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      hi_in    = hi_ff;
      pm_in    = pm_ff;
      msg_in   = msg_ff;
      start    = 1'b0;
      out_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_cipher_coeff[DW-1:0];
               s_in     = req_key_coeff[DW-1:0];
               b_in     = req_cipher_body[DW-1:0];
               last_in  = req_last_coeff;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (q_lt2) begin
               acc_in = '0;
               if (last_ff) begin
                  msg_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               start = 1'b1;
               if (need_a) begin
                  state_in = ST_RED_A;
               end else if (need_s) begin
                  state_in = ST_RED_S;
               end else if (need_acc) begin
                  state_in = ST_RED_ACC;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_RED_A, ST_RED_S, ST_RED_ACC, ST_MUL, ST_RED_B, ST_RED_PH, ST_RED_QP: begin
            r_in   = unit_out;
            src_in = src_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (iter_done) begin
               case (state_ff)
                  ST_RED_A: begin
                     a_in  = unit_out[DW-1:0];
                     start = 1'b1;
                     if (need_s) begin
                        state_in = ST_RED_S;
                     end else if (need_acc) begin
                        state_in = ST_RED_ACC;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  ST_RED_S: begin
                     s_in  = unit_out[DW-1:0];
                     start = 1'b1;
                     state_in = need_acc ? ST_RED_ACC : ST_MUL;
                  end
                  ST_RED_ACC: begin
                     acc_in   = unit_out[DW-1:0];
                     start    = 1'b1;
                     state_in = ST_MUL;
                  end
                  ST_MUL: begin
                     state_in = ST_SUM;
                  end
                  ST_RED_B: begin
                     b_in     = unit_out[DW-1:0];
                     state_in = ST_PHASE;
                  end
                  ST_RED_PH: begin
                     pm_in = unit_out[MSG_W-1:0];
                     if (hi_ff) begin
                        start    = 1'b1;
                        state_in = ST_RED_QP;
                     end else begin
                        msg_in   = unit_out[MSG_W-1:0];
                        state_in = ST_EMIT;
                     end
                  end
                  ST_RED_QP: begin
                     msg_in   = (pm_ff >= qm) ? (pm_ff - qm) : center_sum[MSG_W-1:0];
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUM: begin
            // hold the inner product in the accumulator; a last word clears it after the phase
            acc_in = unit_out[DW-1:0];
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (need_b) begin
               start    = 1'b1;
               state_in = ST_RED_B;
            end else begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            phase_in = phase_calc;
            hi_in    = (phase_calc > (q_ff >> 1));
            acc_in   = '0;
            if (p_ff == '0) begin
               msg_in   = '0;
               state_in = ST_EMIT;
            end else begin
               start    = 1'b1;
               state_in = ST_RED_PH;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Prime the bit-serial pass for the step being entered
      if (start) begin
         r_in   = '0;
         cnt_in = CNT_MAX;
         case (state_in)
            ST_RED_A:          src_in = a_in;
            ST_RED_S, ST_MUL:  src_in = s_in;
            ST_RED_ACC:        src_in = acc_in;
            ST_RED_B:          src_in = b_in;
            ST_RED_PH:         src_in = phase_in;
            ST_RED_QP:         src_in = q_ff;
            default:           src_in = src_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         q_ff         <= CIPHER_MODULUS_RESET[DW-1:0];
         p_ff         <= PLAIN_MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CIPHER_MODULUS: q_ff <= csr_wdata[DW-1:0];
               CSR_PLAIN_MODULUS:  p_ff <= csr_wdata[MSG_W-1:0];
               default: begin
               end
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      s_ff     <= s_in;
      b_ff     <= b_in;
      last_ff  <= last_in;
      src_ff   <= src_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      hi_ff    <= hi_in;
      pm_ff    <= pm_in;
      msg_ff   <= msg_in;
      if (out_load) begin
         rsp_message_ff <= msg_ff;
      end
   end

endmodule

[sv/lwe_dec_checker.sv]
// Port-level checks for the LWE decrypt unit, with the bind that attaches them.
module lwe_dec_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lwe_dec_pkg::MSG_W-1:0] rsp_message
);
   import lwe_dec_pkg::*;

   // a result word is never valid right after reset was applied
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // an accepted word keeps the unit busy on the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an accept");

   // a new result word is produced only while a word is being worked on
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without work in progress");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_message)))
      else $error("stalled result word changed");

endmodule

bind lwe_decrypt_unit lwe_dec_checker u_lwe_dec_checker (.*);
